// File: hdl/pdrf_pkg.sv
// Package for the packet deny rule filter.
// Holds table sizing, protocol numbers, command codes and the stored rule layout.
// No dependencies.
package pdrf_pkg;

  // Rule table sizing.
  localparam int MAX_RULES = 16;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int HIT_W     = 4;

  // Command codes carried on in_command.
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_APPEND   = 1'b1;

  // Append status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // IPv4 protocol numbers.
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // One stored deny rule, 54 bits.
  typedef struct packed {
    logic        is_tcp;
    logic        any_ifc;
    logic [3:0]  ifc;
    logic [31:0] src_addr;
    logic [15:0] port;
  } rule_t;

endpackage

// File: hdl/packet_deny_rule_filter_core.sv
// Top level of the packet deny rule filter: rule table, walk sequencer and result register.
// Depends on pdrf_pkg.
//
// Usage:
//   One input beat on in_* carries either an append command (a new deny rule) or a
//   classify command (fields of one packet). Every input beat yields exactly one
//   result beat on out_*: drop, status and hit_index.
//   An append goes straight from idle to the done state. A full table refuses
//   it with status 1 and leaves the table unchanged.
//   A classify walks the rule table in order, one rule per cycle, from a rule memory
//   with one write port and one registered read port. The walk examines rules up to
//   the rule count, at most MAX_RULES; the first matching rule stops the walk. In the
//   done state the result waits until the output register is free, then loads it.
//   in_ready is high only while the sequencer is idle, so a new beat is not taken
//   until the previous one has left the done state.
//   The output register lets a new beat be accepted while the previous result still
//   waits; a finished result then holds in the sequencer, so a stalled receiver
//   stalls the input side after one more beat.
//   Reset (rst_n low, synchronous) empties the table by clearing the rule count and
//   drops any pending result; entries at or above the rule count are never matched.
module packet_deny_rule_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [3:0]  in_pkt_interface,
  input  logic [31:0] in_pkt_src_addr,
  input  logic [7:0]  in_pkt_protocol,
  input  logic [15:0] in_pkt_dst_port,
  input  logic        in_rule_any_interface,
  input  logic [3:0]  in_rule_interface,
  input  logic [31:0] in_rule_src_addr,
  input  logic [15:0] in_rule_port,
  input  logic        in_rule_is_tcp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drop,
  output logic        out_status,
  output logic [3:0]  out_hit_index
);
  import pdrf_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Packet fields captured at acceptance.
  logic [3:0]  pkt_ifc_r;
  logic [31:0] pkt_addr_r;
  logic [7:0]  pkt_proto_r;
  logic [15:0] pkt_port_r;

  // Pending result held by the sequencer.
  logic             res_drop_r, res_drop_nxt;
  logic             res_status_r, res_status_nxt;
  logic [HIT_W-1:0] res_hit_r, res_hit_nxt;

  // Output register.
  logic             out_valid_r;
  logic             out_drop_r;
  logic             out_status_r;
  logic [HIT_W-1:0] out_hit_r;

  // Rule memory with registered read.
  rule_t            rule_mem [MAX_RULES];
  rule_t            rd_rule_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic             in_fire;
  logic             table_full;
  logic             out_free;
  logic             rule_hit;
  logic             last_rule;
  logic [7:0]       rule_proto;
  logic [IDX_W:0]   idx_inc;
  logic [31:0]      idx_ext;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign table_full = (count_r >= CNT_W'(MAX_RULES));
  assign wr_en      = in_fire && (in_command == CMD_APPEND) && !table_full;
  assign out_free   = !out_valid_r || out_ready;

  // The walk reads entry 0 on acceptance, then the next entry each cycle.
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign rd_addr = (state_r == ST_IDLE) ? '0 : idx_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[count_r[IDX_W-1:0]] <= '{is_tcp:   in_rule_is_tcp,
                                        any_ifc:  in_rule_any_interface,
                                        ifc:      in_rule_interface,
                                        src_addr: in_rule_src_addr,
                                        port:     in_rule_port};
    end
    rd_rule_r <= rule_mem[rd_addr];
  end

  // Match of the currently read rule against the captured packet.
  assign rule_proto = rd_rule_r.is_tcp ? PROTO_TCP : PROTO_UDP;
  assign rule_hit   = (rd_rule_r.any_ifc || (rd_rule_r.ifc == pkt_ifc_r)) &&
                      ((rd_rule_r.src_addr == '0) || (rd_rule_r.src_addr == pkt_addr_r)) &&
                      (rule_proto == pkt_proto_r) &&
                      ((rd_rule_r.port == '0) || (rd_rule_r.port == pkt_port_r));
  assign last_rule  = ({{(CNT_W > IDX_W ? CNT_W - IDX_W : 1){1'b0}}, idx_inc}
                       >= {{(IDX_W + 1 > CNT_W ? IDX_W + 1 - CNT_W : 1){1'b0}}, count_r});
  assign idx_ext    = 32'(idx_r);

  // Sequencer next state.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_drop_nxt   = res_drop_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt        = '0;
          res_drop_nxt   = 1'b0;
          res_status_nxt = STATUS_OK;
          res_hit_nxt    = '0;
          if (in_command == CMD_APPEND) begin
            if (table_full) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
            end
            state_nxt = ST_DONE;
          end else if (count_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (rule_hit) begin
          res_drop_nxt = 1'b1;
          res_hit_nxt  = idx_ext[HIT_W-1:0];
          state_nxt    = ST_DONE;
        end else if (last_rule) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_drop_r   <= res_drop_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    if (in_fire) begin
      pkt_ifc_r   <= in_pkt_interface;
      pkt_addr_r  <= in_pkt_src_addr;
      pkt_proto_r <= in_pkt_protocol;
      pkt_port_r  <= in_pkt_dst_port;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_drop_r   <= res_drop_r;
      out_status_r <= res_status_r;
      out_hit_r    <= res_hit_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drop      = out_drop_r;
  assign out_status    = out_status_r;
  assign out_hit_index = out_hit_r;

endmodule

// File: bench/packet_deny_rule_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_deny_rule_filter_core: a directed table, then random
// appends and classify beats, random stalls on both sides, checks against a behavioral model.
// Depends on pdrf_pkg and the core RTL.
module packet_deny_rule_filter_core_tb;
  import pdrf_pkg::*;

  localparam int RANDOM_BEATS     = 830;
  localparam int LONG_HOLD_AT     = 150;  // result count at which the receiver stalls for long
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_AT         = 600;  // beat at which the sender waits for every result
  localparam int BURST_LO         = 350;  // beats and results in this range see no idling
  localparam int BURST_HI         = 450;
  localparam int SETTLE_CYCLES    = 2 * MAX_RULES + 8;
  localparam logic TYPED          = 1'b1;
  localparam logic PREDICTED      = 1'b0;

  // One input beat, every field of the input channel.
  typedef struct packed {
    logic        cmd;
    logic [3:0]  pkt_ifc;
    logic [31:0] pkt_addr;
    logic [7:0]  pkt_proto;
    logic [15:0] pkt_port;
    logic        rule_any;
    logic [3:0]  rule_ifc;
    logic [31:0] rule_addr;
    logic [15:0] rule_port;
    logic        rule_tcp;
  } beat_t;

  typedef struct packed {
    logic       drop;
    logic       status;
    logic [3:0] hit;
  } verdict_t;

  // A directed row: the beat and, where it is obvious, the verdict typed in by hand.
  typedef struct packed {
    beat_t    beat;
    logic     known;
    verdict_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  beat_t       in_beat;
  logic        out_valid;
  logic        out_ready;
  logic        out_drop;
  logic        out_status;
  logic [3:0]  out_hit_index;

  // Model of the deny table and the verdicts still owed by the block.
  rule_t       deny_table [MAX_RULES];
  int          deny_count;
  verdict_t    verdict_q [$];
  row_t        dir_rows [$];
  int          mismatches;

  packet_deny_rule_filter_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_beat.cmd),
    .in_pkt_interface      (in_beat.pkt_ifc),
    .in_pkt_src_addr       (in_beat.pkt_addr),
    .in_pkt_protocol       (in_beat.pkt_proto),
    .in_pkt_dst_port       (in_beat.pkt_port),
    .in_rule_any_interface (in_beat.rule_any),
    .in_rule_interface     (in_beat.rule_ifc),
    .in_rule_src_addr      (in_beat.rule_addr),
    .in_rule_port          (in_beat.rule_port),
    .in_rule_is_tcp        (in_beat.rule_tcp),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_drop              (out_drop),
    .out_status            (out_status),
    .out_hit_index         (out_hit_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one beat to the table model and returns the verdict the block must give.
  function automatic verdict_t filter_verdict(beat_t b);
    verdict_t   v;
    rule_t      r;
    logic [7:0] proto;
    v = '0;
    if (b.cmd == CMD_APPEND) begin
      if (deny_count >= MAX_RULES) begin
        v.status = STATUS_FULL;
      end else begin
        r.is_tcp   = b.rule_tcp;
        r.any_ifc  = b.rule_any;
        r.ifc      = b.rule_ifc;
        r.src_addr = b.rule_addr;
        r.port     = b.rule_port;
        deny_table[deny_count] = r;
        deny_count++;
      end
    end else begin
      // Walk the rules in order; the first one that matches decides.
      for (int i = 0; i < deny_count; i++) begin
        r = deny_table[i];
        proto = r.is_tcp ? PROTO_TCP : PROTO_UDP;
        if (!v.drop && (r.any_ifc || r.ifc == b.pkt_ifc) &&
            (r.src_addr == '0 || r.src_addr == b.pkt_addr) && proto == b.pkt_proto &&
            (r.port == '0 || r.port == b.pkt_port)) begin
          v.drop = 1'b1;
          v.hit  = 4'(i);
        end
      end
    end
    return v;
  endfunction

  function automatic beat_t pkt(logic [3:0] ifc, logic [31:0] addr, logic [7:0] proto,
                                logic [15:0] port);
    beat_t b;
    b           = '0;
    b.cmd       = CMD_CLASSIFY;
    b.pkt_ifc   = ifc;
    b.pkt_addr  = addr;
    b.pkt_proto = proto;
    b.pkt_port  = port;
    return b;
  endfunction

  function automatic beat_t rule(logic any, logic [3:0] ifc, logic [31:0] addr,
                                 logic [15:0] port, logic tcp);
    beat_t b;
    b           = '1;
    b.cmd       = CMD_APPEND;
    b.rule_any  = any;
    b.rule_ifc  = ifc;
    b.rule_addr = addr;
    b.rule_port = port;
    b.rule_tcp  = tcp;
    return b;
  endfunction

  function automatic row_t row(beat_t b, logic known, logic drop, logic status,
                               logic [3:0] hit);
    row_t r;
    r.beat        = b;
    r.known       = known;
    r.want.drop   = drop;
    r.want.status = status;
    r.want.hit    = hit;
    return r;
  endfunction

  // Random beat: mostly packets aimed at a stored rule, some near misses, some appends.
  function automatic beat_t random_beat();
    beat_t b;
    rule_t r;
    b.cmd       = CMD_CLASSIFY;
    b.pkt_ifc   = 4'($urandom);
    b.pkt_addr  = $urandom;
    b.pkt_proto = 8'($urandom);
    b.pkt_port  = 16'($urandom);
    b.rule_any  = 1'($urandom);
    b.rule_ifc  = 4'($urandom);
    b.rule_addr = $urandom;
    b.rule_port = 16'($urandom);
    b.rule_tcp  = 1'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      b.cmd      = CMD_APPEND;
      b.rule_any = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) b.rule_addr = '0;
      if ($urandom_range(0, 3) == 0) b.rule_port = '0;
    end else if (deny_count > 0 && $urandom_range(0, 9) < 7) begin
      r = deny_table[$urandom_range(0, deny_count - 1)];
      if (!r.any_ifc) b.pkt_ifc = r.ifc;
      if (r.src_addr != '0) b.pkt_addr = r.src_addr;
      b.pkt_proto = r.is_tcp ? PROTO_TCP : PROTO_UDP;
      if (r.port != '0) b.pkt_port = r.port;
      // Now and then spoil one field so the packet lands just beside the rule.
      case ($urandom_range(0, 9))
        0: b.pkt_ifc = b.pkt_ifc ^ 4'(1 << $urandom_range(0, 3));
        1: b.pkt_addr = b.pkt_addr ^ (32'd1 << $urandom_range(0, 31));
        2: b.pkt_proto = 8'($urandom);
        3: b.pkt_port = b.pkt_port ^ 16'(1 << $urandom_range(0, 15));
        default: ;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: b.pkt_proto = PROTO_TCP;
        1: b.pkt_proto = PROTO_UDP;
        default: ;
      endcase
    end
    return b;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Directed rows: empty table, extremes, each wildcard, other protocols, first match wins.
  initial begin
    dir_rows.push_back(row(pkt(4'hF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF), TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'h0, 32'h0, 8'h00, 16'h0), TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'h0, 32'h0, PROTO_TCP, 16'h0), TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(rule(1'b0, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1),
                           TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'hF, 32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF),
                           TYPED, 1, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'hF, 32'hFFFF_FFFF, PROTO_UDP, 16'hFFFF),
                           TYPED, 0, STATUS_OK, 0));
    // A protocol other than TCP or UDP never matches.
    dir_rows.push_back(row(pkt(4'hF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF), TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'hE, 32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF), PREDICTED, 0, 0, 0));
    // Any interface and any port, UDP only.
    dir_rows.push_back(row(rule(1'b1, 4'h0, 32'h0A00_0001, 16'h0, 1'b0),
                           TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'h3, 32'h0A00_0001, PROTO_UDP, 16'd1234),
                           TYPED, 1, STATUS_OK, 1));
    // The port wildcard still needs the protocol to match.
    dir_rows.push_back(row(pkt(4'h3, 32'h0A00_0001, PROTO_TCP, 16'd1234),
                           TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'h0, 32'h0A00_0001, PROTO_UDP, 16'h0), PREDICTED, 0, 0, 0));
    // Any source address, UDP port 53 on interface 0.
    dir_rows.push_back(row(rule(1'b0, 4'h0, 32'h0, 16'd53, 1'b0), TYPED, 0, STATUS_OK, 0));
    dir_rows.push_back(row(pkt(4'h0, 32'hC0A8_0001, PROTO_UDP, 16'd53),
                           TYPED, 1, STATUS_OK, 2));
    dir_rows.push_back(row(pkt(4'h1, 32'hC0A8_0001, PROTO_UDP, 16'd53), PREDICTED, 0, 0, 0));
    // Two rules match; the earlier one is reported.
    dir_rows.push_back(row(pkt(4'h0, 32'h0A00_0001, PROTO_UDP, 16'd53),
                           TYPED, 1, STATUS_OK, 1));
    dir_rows.push_back(row(pkt(4'h0, 32'h0, PROTO_UDP, 16'd53), PREDICTED, 0, 0, 0));
  end

  // Reset, then the sender: directed rows followed by random beats.
  initial begin
    beat_t    b;
    verdict_t v;
    int       gap;
    int       total;
    mismatches = 0;
    deny_count = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_beat    = '0;
    out_ready  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    total = dir_rows.size() + RANDOM_BEATS;
    for (int n = 0; n < total; n++) begin
      @(negedge clk);
      // Let the block run dry once before going on.
      if (n == DRAIN_AT) begin
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      gap = (n >= BURST_LO && n < BURST_HI) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      b = (n < dir_rows.size()) ? dir_rows[n].beat : random_beat();
      in_beat  <= b;
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      // Beat accepted at this edge.
      v = filter_verdict(b);
      if (n < dir_rows.size() && dir_rows[n].known) v = dir_rows[n].want;
      verdict_q.push_back(v);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, one long stall, each result checked against the oldest verdict.
  initial begin
    int       stall;
    int       seen;
    verdict_t want;
    seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (seen == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      else if (seen >= BURST_LO && seen < BURST_HI) stall = 0;
      else stall = $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", seen));
      end else begin
        want = verdict_q.pop_front();
        if (out_drop !== want.drop)
          report_mismatch($sformatf("result %0d drop %0d, expected %0d",
                                    seen, out_drop, want.drop));
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    seen, out_status, want.status));
        if (out_hit_index !== want.hit)
          report_mismatch($sformatf("result %0d hit_index %0d, expected %0d",
                                    seen, out_hit_index, want.hit));
      end
      seen++;
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
